### hdl/htfd_pkg.sv
// shared types, constants and the crc-8 step for the frame decoder
// no dependencies
package htfd_pkg;

    // crc-8, polynomial x^8 + x^5 + x^4 + 1, msb first
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // conversion scale factors and offsets, all in hundredths
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [13:0] HUM_SPAN    = 14'd12500;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0] HUM_OFFSET  = 14'd600;
    localparam logic [13:0] HUM_MAX     = 14'd10000;

    // product widths: 0xffff times the span
    localparam int TEMP_PROD_W = 31;
    localparam int HUM_PROD_W  = 30;

    // words of one reply, handed to the converter
    typedef struct packed {
        logic [15:0] temp_word;
        logic [15:0] hum_word;
        logic        crc_bad;
    } t_frame;

    // one byte through the crc register
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### hdl/humidity_temperature_frame_decoder_unit.sv
// a result passes through the product register and then the result register once the sixth byte of a reply is accepted
// throughput: one byte per cycle while o_ready is high; the crc step and the constant multiply each take one stage
// a stalled result holds the byte input only once both conversion stages are full
// reset (synchronous, active low) clears the byte count, the crc register and all valids
// top level of the frame decoder; depends on htfd_pkg and htfd_convert
module humidity_temperature_frame_decoder_unit
    import htfd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic        [7:0]  i_data_byte,
    input  logic               i_frame_start,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [14:0] o_temperature_centi,
    output logic        [13:0] o_humidity_centi,
    output logic               o_crc_error
);

    // byte positions within a reply
    localparam logic [2:0] IDX_T_HI  = 3'd0;
    localparam logic [2:0] IDX_T_LO  = 3'd1;
    localparam logic [2:0] IDX_T_CRC = 3'd2;
    localparam logic [2:0] IDX_H_HI  = 3'd3;
    localparam logic [2:0] IDX_H_LO  = 3'd4;
    localparam logic [2:0] IDX_H_CRC = 3'd5;

    logic [2:0]  r_idx;
    logic [7:0]  r_crc;
    logic [15:0] r_temp;
    logic [7:0]  r_hum_hi;
    logic        r_temp_bad;
    logic [15:0] r_hum;

    logic [2:0]  n_idx;
    logic [7:0]  n_crc;
    logic [15:0] n_temp;
    logic [7:0]  n_hum_hi;
    logic        n_temp_bad;
    logic [15:0] n_hum;

    logic [2:0]  w_pos;
    logic        w_take;
    logic        w_launch;
    logic        w_conv_ready;
    t_frame      w_frame;

    assign w_take  = i_valid && o_ready;
    assign o_ready = w_conv_ready;

    // a start mark or an unused count value restarts at the first byte
    assign w_pos = (i_frame_start || r_idx > IDX_H_CRC) ? IDX_T_HI : r_idx;

    // byte parser
    always_comb begin
        n_idx      = r_idx;
        n_crc      = r_crc;
        n_temp     = r_temp;
        n_hum_hi   = r_hum_hi;
        n_temp_bad = r_temp_bad;
        n_hum      = r_hum;
        w_launch   = 1'b0;
        case (w_pos)
            IDX_T_HI: begin
                n_crc  = crc8_step(CRC_INIT, i_data_byte);
                n_temp = {i_data_byte, 8'h00};
                n_idx  = IDX_T_LO;
            end
            IDX_T_LO: begin
                n_crc  = crc8_step(r_crc, i_data_byte);
                n_temp = {r_temp[15:8], i_data_byte};
                n_idx  = IDX_T_CRC;
            end
            IDX_T_CRC: begin
                n_temp_bad = (r_crc != i_data_byte);
                n_idx      = IDX_H_HI;
            end
            IDX_H_HI: begin
                n_crc    = crc8_step(CRC_INIT, i_data_byte);
                n_hum_hi = i_data_byte;
                n_idx    = IDX_H_LO;
            end
            IDX_H_LO: begin
                n_crc = crc8_step(r_crc, i_data_byte);
                n_hum = {r_hum_hi, i_data_byte};
                n_idx = IDX_H_CRC;
            end
            default: begin
                w_launch = 1'b1;
                n_idx    = IDX_T_HI;
            end
        endcase
    end

    // frame handed on at the humidity crc byte
    assign w_frame.temp_word = r_temp;
    assign w_frame.hum_word  = r_hum;
    assign w_frame.crc_bad   = r_temp_bad || (r_crc != i_data_byte);

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= IDX_T_HI;
            r_crc <= CRC_INIT;
        end else if (w_take) begin
            r_idx <= n_idx;
            r_crc <= n_crc;
        end
        if (w_take) begin
            r_temp     <= n_temp;
            r_hum_hi   <= n_hum_hi;
            r_temp_bad <= n_temp_bad;
            r_hum      <= n_hum;
        end
    end

    htfd_convert u_convert (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_frame_valid       (w_take && w_launch),
        .i_frame             (w_frame),
        .o_frame_ready       (w_conv_ready),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_temperature_centi (o_temperature_centi),
        .o_humidity_centi    (o_humidity_centi),
        .o_crc_error         (o_crc_error)
    );

endmodule

### hdl/htfd_convert.sv
// two-stage scaling of the received words to hundredths, with output register
// depends on htfd_pkg
module htfd_convert
    import htfd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_frame_valid,
    input  t_frame             i_frame,
    output logic               o_frame_ready,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [14:0] o_temperature_centi,
    output logic        [13:0] o_humidity_centi,
    output logic               o_crc_error
);

    logic                   r_p_valid;
    logic [TEMP_PROD_W-1:0] r_pt;
    logic [HUM_PROD_W-1:0]  r_ph;
    logic                   r_p_bad;
    logic                   r_o_valid;

    logic        w_out_en;
    logic [31:0] w_sum_t;
    logic [31:0] w_sum_h;
    logic [15:0] w_qt;
    logic [15:0] w_qh;
    logic signed [14:0] n_temp;
    logic [13:0] n_hum;

    // output slot free or being emptied
    assign w_out_en      = !r_o_valid || i_ready;
    assign o_frame_ready = !r_p_valid || w_out_en;

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (o_frame_ready) begin
            r_p_valid <= i_frame_valid;
        end
        if (o_frame_ready && i_frame_valid) begin
            r_pt    <= TEMP_PROD_W'(i_frame.temp_word) * TEMP_PROD_W'(TEMP_SPAN);
            r_ph    <= HUM_PROD_W'(i_frame.hum_word) * HUM_PROD_W'(HUM_SPAN);
            r_p_bad <= i_frame.crc_bad;
        end
    end

    // divide by 65535: (p + (p >> 16) + 1) >> 16, exact while the quotient fits 16 bits
    assign w_sum_t = 32'(r_pt) + 32'(r_pt[TEMP_PROD_W-1:16]) + 32'd1;
    assign w_sum_h = 32'(r_ph) + 32'(r_ph[HUM_PROD_W-1:16]) + 32'd1;
    assign w_qt    = w_sum_t[31:16];
    assign w_qh    = w_sum_h[31:16];

    // offset, clamp and error masking
    always_comb begin
        n_temp = $signed(w_qt[14:0] - TEMP_OFFSET);
        if (w_qh[13:0] < HUM_OFFSET) begin
            n_hum = '0;
        end else if (w_qh[13:0] - HUM_OFFSET > HUM_MAX) begin
            n_hum = HUM_MAX;
        end else begin
            n_hum = w_qh[13:0] - HUM_OFFSET;
        end
        if (r_p_bad) begin
            n_temp = '0;
            n_hum  = '0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_en) begin
            r_o_valid <= r_p_valid;
        end
        if (w_out_en && r_p_valid) begin
            o_temperature_centi <= n_temp;
            o_humidity_centi    <= n_hum;
            o_crc_error         <= r_p_bad;
        end
    end

    assign o_valid = r_o_valid;

endmodule

### hdl/htfd_checker.sv
// port-level checks on the frame decoder result channel, bound to the top level
// depends on humidity_temperature_frame_decoder_unit
module htfd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [14:0] o_temperature_centi,
    input logic        [13:0] o_humidity_centi,
    input logic               o_crc_error
);

    // a stalled request keeps its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_temperature_centi)
            && $stable(o_humidity_centi) && $stable(o_crc_error))
        else $error("result changed while stalled");

    // checksum failure masks both values
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_crc_error |-> o_temperature_centi == 15'sd0 && o_humidity_centi == 14'd0)
        else $error("values not zero on crc error");

    // good results stay inside the sensor range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_crc_error |-> o_humidity_centi <= 14'd10000
            && o_temperature_centi >= -15'sd4500 && o_temperature_centi <= 15'sd13000)
        else $error("result out of range");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind humidity_temperature_frame_decoder_unit htfd_checker u_htfd_checker (.*);

### bench/tb_top.sv
`timescale 1ns / 100ps
// self-checking bench for the humidity/temperature reply decoder: a scoreboard class
// predicts each reading from the accepted bytes; depends on htfd_pkg and the decoder rtl

// one decoded reading as the block presents it
typedef struct {
    logic signed [14:0] temp_centi;
    logic        [13:0] hum_centi;
    logic               crc_err;
} reading_t;

// ways of spoiling a reply
typedef enum int {
    CORRUPT_NONE,
    CORRUPT_TEMP_CRC,
    CORRUPT_HUM_CRC,
    CORRUPT_DATA
} corrupt_t;

class reply_scoreboard;
    // copy of the decoder state
    bit [2:0]  byte_pos;
    bit [7:0]  crc_acc;
    bit [15:0] temp_raw;
    bit [7:0]  hum_hi;
    bit        temp_bad;
    bit [15:0] hum_raw;

    reading_t  pending_readings[$];
    int        errors;
    int        checked;
    int        crc_errs;
    int        clamped;
    int        bytes_seen;

    function new();
        byte_pos   = 3'd0;
        crc_acc    = htfd_pkg::CRC_INIT;
        temp_raw   = 16'h0000;
        hum_hi     = 8'h00;
        temp_bad   = 1'b0;
        hum_raw    = 16'h0000;
        errors     = 0;
        checked    = 0;
        crc_errs   = 0;
        clamped    = 0;
        bytes_seen = 0;
    endfunction

    // crc-8 taken one data bit at a time, msb first
    static function bit [7:0] crc8(bit [7:0] crc, bit [7:0] b);
        bit [7:0] c;
        bit       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ b[i];
            c  = c << 1;
            if (fb) begin
                c = c ^ htfd_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    function void report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endfunction

    // accepted byte request: advance the decoder copy, queue a reading after byte six
    function void note_request(bit [7:0] b, bit start);
        int unsigned pos;
        int unsigned prod;
        int          t;
        int          h;
        reading_t    r;
        bytes_seen++;
        pos = byte_pos;
        if (start || pos > 5) begin
            pos = 0;
        end
        case (pos)
            0: begin
                crc_acc  = crc8(htfd_pkg::CRC_INIT, b);
                temp_raw = {b, 8'h00};
                byte_pos = 3'd1;
            end
            1: begin
                crc_acc       = crc8(crc_acc, b);
                temp_raw[7:0] = b;
                byte_pos      = 3'd2;
            end
            2: begin
                temp_bad = (crc_acc != b);
                byte_pos = 3'd3;
            end
            3: begin
                crc_acc  = crc8(htfd_pkg::CRC_INIT, b);
                hum_hi   = b;
                byte_pos = 3'd4;
            end
            4: begin
                crc_acc  = crc8(crc_acc, b);
                hum_raw  = {hum_hi, b};
                byte_pos = 3'd5;
            end
            default: begin
                byte_pos = 3'd0;
                if (temp_bad || crc_acc != b) begin
                    r.temp_centi = '0;
                    r.hum_centi  = '0;
                    r.crc_err    = 1'b1;
                end else begin
                    prod = 32'(temp_raw) * 32'd17500;
                    t    = -4500 + int'(prod / 32'd65535);
                    prod = 32'(hum_raw) * 32'd12500;
                    h    = -600 + int'(prod / 32'd65535);
                    if (h < 0 || h > 10000) begin
                        clamped++;
                    end
                    if (h < 0) begin
                        h = 0;
                    end
                    if (h > 10000) begin
                        h = 10000;
                    end
                    r.temp_centi = t[14:0];
                    r.hum_centi  = h[13:0];
                    r.crc_err    = 1'b0;
                end
                pending_readings.push_back(r);
            end
        endcase
    endfunction

    // accepted result request: compare with the oldest outstanding reading
    function void check_result(logic signed [14:0] t, logic [13:0] h, logic e);
        reading_t x;
        if (pending_readings.size() == 0) begin
            report($sformatf("reading t=%0d h=%0d err=%b with none outstanding", t, h, e));
            return;
        end
        x = pending_readings.pop_front();
        checked++;
        if (x.crc_err) begin
            crc_errs++;
        end
        if (t !== x.temp_centi) begin
            report($sformatf("reading %0d temperature %0d, wanted %0d", checked, t,
                             x.temp_centi));
        end
        if (h !== x.hum_centi) begin
            report($sformatf("reading %0d humidity %0d, wanted %0d", checked, h,
                             x.hum_centi));
        end
        if (e !== x.crc_err) begin
            report($sformatf("reading %0d crc flag %b, wanted %b", checked, e, x.crc_err));
        end
    endfunction

    function int outstanding();
        return pending_readings.size();
    endfunction

    // anything still queued at the end never arrived
    function void flush_leftovers();
        while (pending_readings.size() != 0) begin
            void'(pending_readings.pop_front());
            report("reading never delivered");
        end
    endfunction
endclass

module tb_top;
    import htfd_pkg::*;

    localparam int ITEMS       = 1250;
    localparam int QUIET_TAIL  = 150;
    localparam int CYCLE_LIMIT = 200000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic        [7:0]  i_data_byte;
    logic               i_frame_start;
    logic               o_valid;
    logic               i_ready;
    logic signed [14:0] o_temperature_centi;
    logic        [13:0] o_humidity_centi;
    logic               o_crc_error;

    reply_scoreboard sb;
    int              idle_pct;
    int              bytes_sent;
    int              cycle_count;
    int              ready_hold;
    bit              aligned;

    humidity_temperature_frame_decoder_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_data_byte         (i_data_byte),
        .i_frame_start       (i_frame_start),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_temperature_centi (o_temperature_centi),
        .o_humidity_centi    (o_humidity_centi),
        .o_crc_error         (o_crc_error)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("FAIL");
                $finish;
            end
        end
    end

    // result side back-pressure in short bursts
    initial begin
        i_ready    = 1'b0;
        ready_hold = 0;
        forever begin
            @(negedge i_clk);
            if (ready_hold > 0) begin
                ready_hold--;
                i_ready <= 1'b0;
            end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                ready_hold = $urandom_range(0, 2);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // watch both handshakes at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                sb.note_request(i_data_byte, i_frame_start);
            end
            if (o_valid && i_ready) begin
                sb.check_result(o_temperature_centi, o_humidity_centi, o_crc_error);
            end
        end
    end

    // one byte request, with an occasional idle burst in front
    task automatic send_byte(bit [7:0] b, bit start);
        int gap;
        gap = 0;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 3);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_data_byte   <= b;
        i_frame_start <= start;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // build a reply, optionally spoil it, and send its first nbytes bytes
    task automatic send_reply(bit [15:0] tw, bit [15:0] hw, bit start, corrupt_t spoil,
                              int nbytes);
        bit [7:0] fr[6];
        int       k;
        fr[0] = tw[15:8];
        fr[1] = tw[7:0];
        fr[2] = crc8_step(crc8_step(CRC_INIT, fr[0]), fr[1]);
        fr[3] = hw[15:8];
        fr[4] = hw[7:0];
        fr[5] = crc8_step(crc8_step(CRC_INIT, fr[3]), fr[4]);
        case (spoil)
            CORRUPT_TEMP_CRC: fr[2] = fr[2] ^ 8'($urandom_range(1, 255));
            CORRUPT_HUM_CRC:  fr[5] = fr[5] ^ 8'($urandom_range(1, 255));
            CORRUPT_DATA: begin
                k     = $urandom_range(0, 3);
                k     = (k > 1) ? k + 1 : k;
                fr[k] = fr[k] ^ 8'($urandom_range(1, 255));
            end
            default: ;
        endcase
        for (int i = 0; i < nbytes; i++) begin
            send_byte(fr[i], (i == 0) ? start : 1'b0);
        end
        aligned = (nbytes == 6);
    endtask

    // mostly uniform words, sometimes the ends of the range
    function automatic bit [15:0] pick_word();
        bit [15:0] edges[4];
        edges = '{16'h0000, 16'h0001, 16'hFFFE, 16'hFFFF};
        if ($urandom_range(0, 7) == 0) begin
            return edges[$urandom_range(0, 3)];
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    // stimulus
    initial begin
        int phase;
        int kind;
        int n;
        sb            = new();
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data_byte   = 8'h00;
        i_frame_start = 1'b0;
        idle_pct      = 0;
        bytes_sent    = 0;
        aligned       = 1'b1;
        phase         = -1;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: range ends, an abandoned reply, wrap without start mark, bad crc
        idle_pct = 25;
        send_reply(16'h0000, 16'hFFFF, 1'b1, CORRUPT_NONE, 6);
        send_reply(16'h1234, 16'h5678, 1'b1, CORRUPT_NONE, 3);
        send_reply(16'hFFFF, 16'h0000, 1'b1, CORRUPT_NONE, 6);
        send_reply(16'h6666, 16'h8000, 1'b0, CORRUPT_TEMP_CRC, 6);

        // random replies, mostly well formed
        while (bytes_sent < ITEMS) begin
            if (ITEMS - bytes_sent < QUIET_TAIL) begin
                idle_pct = 0;
            end else if (bytes_sent / 120 != phase) begin
                phase = bytes_sent / 120;
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 15;
                    default: idle_pct = 40;
                endcase
            end
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                send_reply(pick_word(), pick_word(), aligned ? 1'($urandom_range(0, 1)) : 1'b1,
                           CORRUPT_NONE, 6);
            end else if (kind < 85) begin
                send_reply(pick_word(), pick_word(), aligned ? 1'($urandom_range(0, 1)) : 1'b1,
                           corrupt_t'($urandom_range(1, 3)), 6);
            end else if (kind < 95) begin
                send_reply(pick_word(), pick_word(), 1'b1, CORRUPT_NONE, $urandom_range(1, 5));
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                aligned = 1'b0;
            end
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        // drain, then allow for the pipeline
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        sb.flush_leftovers();

        $display("sent %0d bytes; checked %0d readings, %0d with crc error, %0d clamped",
                 sb.bytes_seen, sb.checked, sb.crc_errs, sb.clamped);
        $display("mismatches: %0d", sb.errors);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
